// ===== sv/ihni_pkg.sv =====
// Package: types, opcode constants and helpers for the hazard NOP inserter.
`default_nettype none
package ihni_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int NUM_CLASSES = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] NOP_WORD = 32'h0000_0013;

	localparam logic [6:0] OP_ALU_R  = 7'b0110011;
	localparam logic [6:0] OP_ALU_I  = 7'b0010011;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef enum logic [2:0] {
		CLS_ALU    = 3'd0,
		CLS_JUMP   = 3'd1,
		CLS_BRANCH = 3'd2,
		CLS_MEMORY = 3'd3,
		CLS_OTHER  = 3'd4
	} cls_t;

	typedef struct packed {
		logic [31:0] word;
		cls_t        cls;
		logic        haz;
		logic [31:0] cnt_total;
		logic [31:0] cnt_alu;
		logic [31:0] cnt_jump;
		logic [31:0] cnt_branch;
		logic [31:0] cnt_memory;
		logic [31:0] cnt_misc;
		logic [31:0] cnt_nops;
	} entry_t;

	function automatic cls_t classify(input logic [6:0] op);
		cls_t c;
		if (op inside {OP_ALU_R, OP_ALU_I})
			c = CLS_ALU;
		else if (op inside {OP_JAL, OP_JALR})
			c = CLS_JUMP;
		else if (op == OP_BRANCH)
			c = CLS_BRANCH;
		else if (op inside {OP_LOAD, OP_STORE})
			c = CLS_MEMORY;
		else
			c = CLS_OTHER;
		return c;
	endfunction

	function automatic count_t sat_inc(input count_t c);
		return (c == '1) ? c : count_t'(c + 1'b1);
	endfunction

	// clamp to the 32-bit reporting field
	function automatic logic [31:0] report_cnt(input count_t c);
		logic [63:0] w;
		w = 64'(c);
		return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/ihni_front.sv =====
// Front end: accepts beats, classifies, checks the hazard and updates counters.
`default_nettype none
module ihni_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [31:0]     instr_word,
	input  wire logic            q_full,
	output logic                 q_push,
	output ihni_pkg::entry_t     q_entry
);
	import ihni_pkg::*;

	logic [4:0] prev_dest_q;
	logic       prev_valid_q;
	count_t     total_q, nop_q;
	count_t     class_q [NUM_CLASSES];
	count_t     total_d, nop_d;
	count_t     class_d [NUM_CLASSES];
	cls_t       cls;
	logic       haz;
	logic [4:0] rs1, rs2;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	assign cls = classify(instr_word[6:0]);
	assign rs1 = instr_word[19:15];
	assign rs2 = instr_word[24:20];
	assign haz = prev_valid_q &&
		((prev_dest_q == rs1) || ((cls != CLS_MEMORY) && (prev_dest_q == rs2)));

	always_comb begin
		total_d = sat_inc(total_q);
		nop_d   = haz ? sat_inc(nop_q) : nop_q;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			class_d[i] = (cls == cls_t'(i)) ? sat_inc(class_q[i]) : class_q[i];
		end
	end

	always_comb begin
		q_entry.word       = instr_word;
		q_entry.cls        = cls;
		q_entry.haz        = haz;
		q_entry.cnt_total  = report_cnt(total_d);
		q_entry.cnt_alu    = report_cnt(class_d[CLS_ALU]);
		q_entry.cnt_jump   = report_cnt(class_d[CLS_JUMP]);
		q_entry.cnt_branch = report_cnt(class_d[CLS_BRANCH]);
		q_entry.cnt_memory = report_cnt(class_d[CLS_MEMORY]);
		q_entry.cnt_misc   = report_cnt(class_d[CLS_OTHER]);
		q_entry.cnt_nops   = report_cnt(nop_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_dest_q  <= '0;
			prev_valid_q <= 1'b0;
			total_q      <= '0;
			nop_q        <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) class_q[i] <= '0;
		end else if (q_push) begin
			prev_dest_q  <= instr_word[11:7];
			prev_valid_q <= 1'b1;
			total_q      <= total_d;
			nop_q        <= nop_d;
			for (int i = 0; i < NUM_CLASSES; i++) class_q[i] <= class_d[i];
		end
	end

endmodule
`default_nettype wire

// ===== sv/ihni_queue.sv =====
// Short register queue between front and back end.
`default_nettype none
module ihni_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ihni_pkg::entry_t  wr_entry,
	output logic                   full,
	input  wire logic              pop,
	output ihni_pkg::entry_t       rd_entry,
	output logic                   empty
);
	import ihni_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push, do_pop;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			case ({do_push, do_pop})
				2'b10:   cnt_q <= QCNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= QCNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/ihni_back.sv =====
// Back end: expands queue entries into one or two output beats.
`default_nettype none
module ihni_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire ihni_pkg::entry_t  q_entry,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [31:0]            out_word,
	output logic                   is_inserted_nop,
	output logic                   last_of_run,
	output logic [2:0]             instr_class,
	output logic                   hazard_found,
	output logic [31:0]            count_total,
	output logic [31:0]            count_alu,
	output logic [31:0]            count_jump,
	output logic [31:0]            count_branch,
	output logic [31:0]            count_memory,
	output logic [31:0]            count_misc,
	output logic [31:0]            count_nops_added
);
	import ihni_pkg::*;

	entry_t out_entry_q;
	logic   out_valid_q;
	logic   out_nop_q;
	logic   load;
	logic   second_beat;

	assign load        = !out_valid_q || out_ready;
	assign second_beat = out_valid_q && out_nop_q;
	assign q_pop       = load && !second_beat && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop) out_entry_q <= q_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_nop_q   <= 1'b0;
		end else if (load) begin
			if (second_beat) begin
				out_valid_q <= 1'b1;
				out_nop_q   <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				out_nop_q   <= q_entry.haz;
			end else begin
				out_valid_q <= 1'b0;
				out_nop_q   <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_word         = out_nop_q ? NOP_WORD : out_entry_q.word;
	assign is_inserted_nop  = out_nop_q;
	assign last_of_run      = !out_nop_q;
	assign instr_class      = out_entry_q.cls;
	assign hazard_found     = out_entry_q.haz;
	assign count_total      = out_entry_q.cnt_total;
	assign count_alu        = out_entry_q.cnt_alu;
	assign count_jump       = out_entry_q.cnt_jump;
	assign count_branch     = out_entry_q.cnt_branch;
	assign count_memory     = out_entry_q.cnt_memory;
	assign count_misc       = out_entry_q.cnt_misc;
	assign count_nops_added = out_entry_q.cnt_nops;

endmodule
`default_nettype wire

// ===== sv/instr_hazard_nop_inserter.sv =====
// Top level: instruction hazard NOP inserter.
// An accepted beat is written into the queue, then loaded into the output register to be shown.
// Throughput: one instruction per cycle while out_ready stays high; an instruction with a
// hazard goes out as a NOP beat then the instruction, from the single output register.
// A two-entry queue sits between the classifier and the output stage.
// Reset (arst_n low, asynchronous) clears counters, previous-rd state, queue and output.
`default_nettype none
module instr_hazard_nop_inserter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] instr_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      out_word,
	output logic             is_inserted_nop,
	output logic             last_of_run,
	output logic [2:0]       instr_class,
	output logic             hazard_found,
	output logic [31:0]      count_total,
	output logic [31:0]      count_alu,
	output logic [31:0]      count_jump,
	output logic [31:0]      count_branch,
	output logic [31:0]      count_memory,
	output logic [31:0]      count_misc,
	output logic [31:0]      count_nops_added
);
	import ihni_pkg::*;

	entry_t push_entry, head_entry;
	logic   q_push, q_full, q_pop, q_empty;

	ihni_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.instr_word (instr_word),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (push_entry)
	);

	ihni_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (push_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (head_entry),
		.empty    (q_empty)
	);

	ihni_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_entry          (head_entry),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_word         (out_word),
		.is_inserted_nop  (is_inserted_nop),
		.last_of_run      (last_of_run),
		.instr_class      (instr_class),
		.hazard_found     (hazard_found),
		.count_total      (count_total),
		.count_alu        (count_alu),
		.count_jump       (count_jump),
		.count_branch     (count_branch),
		.count_memory     (count_memory),
		.count_misc       (count_misc),
		.count_nops_added (count_nops_added)
	);

`ifndef ASSERT_OFF
	// a taken NOP beat is always followed by its instruction beat
	a_nop_then_instr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && is_inserted_nop
		|=> out_valid && !is_inserted_nop && last_of_run && $stable(count_total))
		else $error("NOP beat not followed by its instruction");

	a_nop_has_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_inserted_nop |-> hazard_found)
		else $error("NOP beat without hazard");

	a_nops_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count_nops_added <= count_total)
		else $error("NOP count exceeds total");

	// a hazard instruction beat first shows up right after its NOP beat is taken
	a_hazard_nop_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run && hazard_found && !$past(out_valid && last_of_run)
		|-> $past(out_valid && out_ready && is_inserted_nop))
		else $error("hazard instruction beat without preceding NOP");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_instr_hazard_nop_inserter.sv =====
// Self-checking testbench for the instruction hazard NOP inserter.
`timescale 1ns / 1ps
module tb_instr_hazard_nop_inserter;
	import ihni_pkg::*;

	localparam int          RANDOM_ITEMS = 1700;
	localparam int          CALM_FROM    = 1500;
	localparam int          DRAIN_AT     = 800;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam logic [6:0]  OP_FENCE     = 7'b0001111;
	localparam logic [6:0]  OP_LUI       = 7'b0110111;

	typedef struct packed {
		logic [31:0] word;
		logic        pin;
		cls_t        cls;
		logic        haz;
	} row_t;

	typedef struct packed {
		logic [31:0] word;
		logic        nop;
		logic        last;
		cls_t        cls;
		logic        haz;
		logic [31:0] tot;
		logic [31:0] alu;
		logic [31:0] jmp;
		logic [31:0] br;
		logic [31:0] mem;
		logic [31:0] misc;
		logic [31:0] nops;
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] instr_word;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] out_word;
	logic        is_inserted_nop;
	logic        last_of_run;
	logic [2:0]  instr_class;
	logic        hazard_found;
	logic [31:0] count_total;
	logic [31:0] count_alu;
	logic [31:0] count_jump;
	logic [31:0] count_branch;
	logic [31:0] count_memory;
	logic [31:0] count_misc;
	logic [31:0] count_nops_added;

	instr_hazard_nop_inserter u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.instr_word       (instr_word),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_word         (out_word),
		.is_inserted_nop  (is_inserted_nop),
		.last_of_run      (last_of_run),
		.instr_class      (instr_class),
		.hazard_found     (hazard_found),
		.count_total      (count_total),
		.count_alu        (count_alu),
		.count_jump       (count_jump),
		.count_branch     (count_branch),
		.count_memory     (count_memory),
		.count_misc       (count_misc),
		.count_nops_added (count_nops_added)
	);

	// shadow of the block's hazard and counter state
	logic [4:0] last_dest;
	logic       have_last;
	count_t     seen_total;
	count_t     seen_cls [NUM_CLASSES];
	count_t     seen_nops;

	beat_t due_words[$];
	row_t  tag_q[$];
	row_t  plan[$];

	int  errors;
	int  items_sent;
	int  beats_checked;
	int  nops_checked;
	int  cycles;
	int  stall_left;
	bit  tx_idle_en;
	bit  rx_idle_en;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] rv_word(input logic [6:0] op, input logic [4:0] rd,
			input logic [4:0] rs1, input logic [4:0] rs2);
		return {7'b0, rs2, rs1, 3'b0, rd, op};
	endfunction

	function automatic logic [31:0] shown(input count_t c);
		return (64'(c) > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
	endfunction

	function automatic count_t bump(input count_t c);
		return (c == '1) ? c : count_t'(c + 1'b1);
	endfunction

	function automatic logic [31:0] random_word(input logic [4:0] prev_rd);
		logic [31:0] raw;
		logic [6:0]  op;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		raw = $urandom;
		if ($urandom_range(0, 3) == 0)
			return raw;
		case ($urandom_range(0, 9))
			0: op = OP_ALU_R;
			1: op = OP_ALU_I;
			2: op = OP_JAL;
			3: op = OP_JALR;
			4: op = OP_BRANCH;
			5: op = OP_LOAD;
			6: op = OP_STORE;
			7: op = OP_FENCE;
			8: op = OP_LUI;
			default: op = raw[6:0];
		endcase
		rs1 = ($urandom_range(0, 9) < 4) ? prev_rd : raw[19:15];
		rs2 = ($urandom_range(0, 9) < 3) ? prev_rd : raw[24:20];
		rd  = ($urandom_range(0, 4) == 0) ? 5'd0 : raw[11:7];
		return {raw[31:25], rs2, rs1, raw[14:12], rd, op};
	endfunction

	task automatic add_row(input logic [31:0] w, input logic pin, input cls_t c,
			input logic h);
		row_t r;
		r.word = w;
		r.pin  = pin;
		r.cls  = c;
		r.haz  = h;
		plan = {plan, r};
	endtask

	// work out the beats one accepted instruction produces
	task automatic schedule_words(input logic [31:0] w, input row_t tag);
		cls_t  cls;
		logic  haz;
		beat_t b;
		case (w[6:0])
			OP_ALU_R, OP_ALU_I: cls = CLS_ALU;
			OP_JAL, OP_JALR:    cls = CLS_JUMP;
			OP_BRANCH:          cls = CLS_BRANCH;
			OP_LOAD, OP_STORE:  cls = CLS_MEMORY;
			default:            cls = CLS_OTHER;
		endcase
		haz = have_last && (last_dest == w[19:15] ||
			(cls != CLS_MEMORY && last_dest == w[24:20]));
		if (tag.pin) begin
			cls = tag.cls;
			haz = tag.haz;
		end
		seen_cls[cls] = bump(seen_cls[cls]);
		seen_total    = bump(seen_total);
		if (haz)
			seen_nops = bump(seen_nops);
		last_dest = w[11:7];
		have_last = 1'b1;
		b = '{NOP_WORD, 1'b1, 1'b0, cls, haz, shown(seen_total),
			shown(seen_cls[CLS_ALU]), shown(seen_cls[CLS_JUMP]),
			shown(seen_cls[CLS_BRANCH]), shown(seen_cls[CLS_MEMORY]),
			shown(seen_cls[CLS_OTHER]), shown(seen_nops)};
		if (haz)
			due_words = {due_words, b};
		b.word = w;
		b.nop  = 1'b0;
		b.last = 1'b1;
		due_words = {due_words, b};
	endtask

	task automatic cmp(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t mismatch on %s: expected %h, actual %h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : watch
		beat_t b;
		row_t  tag;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_words.size() == 0) begin
					errors++;
					$display("%0t unexpected beat: expected none, actual word %h", $time,
						out_word);
				end else begin
					b = due_words.pop_front();
					cmp("out_word", b.word, out_word);
					cmp("is_inserted_nop", 32'(b.nop), 32'(is_inserted_nop));
					cmp("last_of_run", 32'(b.last), 32'(last_of_run));
					cmp("instr_class", 32'(b.cls), 32'(instr_class));
					cmp("hazard_found", 32'(b.haz), 32'(hazard_found));
					cmp("count_total", b.tot, count_total);
					cmp("count_alu", b.alu, count_alu);
					cmp("count_jump", b.jmp, count_jump);
					cmp("count_branch", b.br, count_branch);
					cmp("count_memory", b.mem, count_memory);
					cmp("count_misc", b.misc, count_misc);
					cmp("count_nops_added", b.nops, count_nops_added);
					beats_checked++;
					if (b.nop)
						nops_checked++;
				end
			end
			if (in_valid && in_ready) begin
				tag = tag_q.pop_front();
				schedule_words(instr_word, tag);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 16);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still pending", cycles,
				due_words.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_word(input row_t r);
		tag_q = {tag_q, r};
		in_valid   <= 1'b1;
		instr_word <= r.word;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic maybe_gap();
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	initial begin
		row_t       r;
		logic [4:0] prev_rd;
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		instr_word = '0;
		out_ready  = 1'b0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		last_dest  = '0;
		have_last  = 1'b0;
		seen_total = '0;
		seen_nops  = '0;
		foreach (seen_cls[k])
			seen_cls[k] = '0;

		// first beat after reset is checked too, with no hazard; x0 and no-destination words still match
		add_row(32'h0000_0000, 1'b1, CLS_OTHER, 1'b0);
		add_row(32'hFFFF_FFFF, 1'b1, CLS_OTHER, 1'b0);
		add_row(rv_word(OP_ALU_R, 5'd1, 5'd31, 5'd2), 1'b1, CLS_ALU, 1'b1);
		add_row(rv_word(OP_ALU_I, 5'd2, 5'd3, 5'd1), 1'b1, CLS_ALU, 1'b1);
		add_row(rv_word(OP_LOAD, 5'd3, 5'd4, 5'd2), 1'b1, CLS_MEMORY, 1'b0);
		add_row(rv_word(OP_STORE, 5'd4, 5'd3, 5'd0), 1'b1, CLS_MEMORY, 1'b1);
		add_row(rv_word(OP_BRANCH, 5'd5, 5'd6, 5'd4), 1'b1, CLS_BRANCH, 1'b1);
		add_row(rv_word(OP_JAL, 5'd0, 5'd7, 5'd8), 1'b1, CLS_JUMP, 1'b0);
		add_row(rv_word(OP_JALR, 5'd9, 5'd0, 5'd10), 1'b1, CLS_JUMP, 1'b1);
		add_row(NOP_WORD, 1'b1, CLS_ALU, 1'b0);
		add_row(NOP_WORD, 1'b1, CLS_ALU, 1'b1);
		add_row(rv_word(OP_FENCE, 5'd10, 5'd1, 5'd2), 1'b1, CLS_OTHER, 1'b0);
		add_row(rv_word(OP_LOAD, 5'd11, 5'd5, 5'd10), 1'b1, CLS_MEMORY, 1'b0);
		add_row(rv_word(OP_STORE, 5'd12, 5'd11, 5'd11), 1'b1, CLS_MEMORY, 1'b1);
		add_row(rv_word(OP_ALU_R, 5'd31, 5'd12, 5'd12), 1'b1, CLS_ALU, 1'b1);
		add_row(rv_word(OP_BRANCH, 5'd13, 5'd0, 5'd0), 1'b1, CLS_BRANCH, 1'b0);
		add_row(32'h8000_0000, 1'b1, CLS_OTHER, 1'b0);
		add_row(32'h7FFF_FFFF, 1'b0, CLS_OTHER, 1'b0);
		add_row(32'hDEAD_BEEF, 1'b0, CLS_OTHER, 1'b0);
		add_row(rv_word(OP_LUI, 5'd14, 5'd15, 5'd16), 1'b0, CLS_OTHER, 1'b0);
		add_row(rv_word(OP_ALU_I, 5'd15, 5'd14, 5'd14), 1'b0, CLS_OTHER, 1'b0);

		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			maybe_gap();
			send_word(plan[i]);
		end

		prev_rd = plan[plan.size()-1].word[11:7];
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			tx_idle_en = (i < CALM_FROM) && ((i / 300) % 4 inside {0, 3});
			rx_idle_en = (i < CALM_FROM) && ((i / 300) % 4 inside {0, 2});
			if (i == DRAIN_AT) begin
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (due_words.size() != 0);
			end
			maybe_gap();
			r = '{random_word(prev_rd), 1'b0, CLS_OTHER, 1'b0};
			prev_rd = r.word[11:7];
			send_word(r);
		end
		in_valid <= 1'b0;

		while (due_words.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);

		$display("%0d instructions driven, %0d output beats checked, %0d inserted NOPs",
			items_sent, beats_checked, nops_checked);
		$display("all opcode classes, x0 and memory-operand hazards, stalls on both sides");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/ihni_pkg.sv
sv/ihni_front.sv
sv/ihni_queue.sv
sv/ihni_back.sv
sv/instr_hazard_nop_inserter.sv
verif/tb_instr_hazard_nop_inserter.sv
